>>> rtl/mie_pkg.sv
// Package for the multilocus inbreeding estimator.
// Fixed-point format, field widths, accumulator width and the sequencer state type.
// No dependencies.
package mie_pkg;

	localparam int FRAC_BITS = 16;		// fraction bits of every fixed-point field
	localparam int FREQ_W = FRAC_BITS + 1;	// Q1.FRAC_BITS frequency and threshold
	localparam int EST_W  = 32;	// signed Q16.16 estimate
	localparam int USED_W = 21;	// used loci count on the result port
	localparam int SUM_W  = 56;	// signed contribution accumulator

	localparam logic [EST_W-1:0] EST_POS_MAX = {1'b0, {(EST_W-1){1'b1}}};
	localparam logic [EST_W-1:0] EST_NEG_MAX = {1'b1, {(EST_W-1){1'b0}}};

	typedef logic [FREQ_W-1:0] freq_t;

	typedef enum logic [2:0] {
		ST_IDLE,	// waiting for a locus
		ST_RECIP,	// bit-serial reciprocal of the frequency
		ST_ACC,		// add contribution, bump count
		ST_MINIT,	// set up the mean division
		ST_MEAN,	// bit-serial sum / count
		ST_LOAD		// hand result to the output register
	} mie_state_t;

endpackage

>>> rtl/multilocus_inbreeding_estimate.sv
// A counted homozygous locus passes through the restoring reciprocal divider, which forms
// one quotient bit per cycle; a heterozygous or ignored locus goes straight to accumulate.
// A last locus then runs the 56-bit mean divider, one bit per cycle, unless no loci were
// counted, and waits in the load state while a stalled result holds the output register.
// One item at a time; a finished result may still sit in the output register meanwhile.
// arst_n clears sum, count, result valid and loads the default threshold.
module multilocus_inbreeding_estimate #(
	parameter int MAX_LOCI  = 1048576
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// locus items
	input  logic                  loc_valid,
	output logic                  loc_stall,
	input  logic                  is_homozygous,
	input  mie_pkg::freq_t        allele_frequency,
	input  logic                  last_locus,
	// result items
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [mie_pkg::EST_W-1:0]  estimate,
	output logic [mie_pkg::USED_W-1:0] used_loci,
	// threshold register write
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  mie_pkg::freq_t        min_frequency
);
	import mie_pkg::*;

	localparam int ONE     = 1 << FRAC_BITS;
	localparam int MINF_RST = (ONE + 500) / 1000;
	localparam int QW      = 2 * FRAC_BITS + 1;		// reciprocal quotient width
	localparam int CW      = QW + 1;			// signed contribution width
	localparam int CNT_W   = $clog2(MAX_LOCI + 1);
	localparam int STEP_W  = $clog2((QW > SUM_W) ? QW : SUM_W);

	mie_state_t state_q, state_d;

	freq_t min_frequency_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic res_valid_q;

	logic homo_q, last_q, add_q;
	freq_t freq_q;
	logic [FREQ_W-1:0] rrem_q;
	logic [QW-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0] mrem_q;
	logic [SUM_W-1:0] mdiv_q;
	logic neg_q;
	logic [EST_W-1:0] estimate_q;
	logic [USED_W-1:0] used_q;

	logic accept, take_thr, res_free;
	logic [FREQ_W:0] rrem2, rrem_sub;
	logic rge, nbit;
	logic [CNT_W:0] mrem2, mrem_sub;
	logic mge;
	logic signed [CW-1:0] contrib;
	logic signed [SUM_W:0] sum_ext;
	logic signed [SUM_W-1:0] sum_next;
	logic [SUM_W-1:0] mag;
	logic [EST_W-1:0] est_c;

	assign cfg_ready = 1'b1;
	assign loc_stall = (state_q != ST_IDLE);
	assign accept    = loc_valid && !loc_stall;
	assign take_thr  = is_homozygous && (allele_frequency > min_frequency_q);
	assign res_free  = !res_valid_q || !res_stall;

	assign res_valid = res_valid_q;
	assign estimate  = estimate_q;
	assign used_loci = used_q;

	// reciprocal: dividend is 2^(2*FRAC_BITS), a single one at the top bit
	assign nbit     = (step_q == STEP_W'(QW - 1));
	assign rrem2    = {rrem_q, nbit};
	assign rge      = rrem2 >= {1'b0, freq_q};
	assign rrem_sub = rrem2 - {1'b0, freq_q};

	// mean: shift register holds dividend, quotient bits enter at the bottom
	assign mrem2    = {mrem_q, mdiv_q[SUM_W-1]};
	assign mge      = mrem2 >= {1'b0, cnt_q};
	assign mrem_sub = mrem2 - {1'b0, cnt_q};

	always_comb begin
		if (homo_q) begin
			contrib = $signed({1'b0, quo_q}) - $signed(CW'(ONE));
		end else begin
			contrib = -$signed(CW'(ONE));
		end
		sum_ext = {sum_q[SUM_W-1], sum_q} + {{(SUM_W + 1 - CW){contrib[CW-1]}}, contrib};
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
			sum_next = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_next = sum_ext[SUM_W-1:0];
		end
		mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	end

	always_comb begin
		if (cnt_q == '0) begin
			est_c = '0;
		end else if (neg_q) begin
			if (mdiv_q > SUM_W'(EST_NEG_MAX)) begin
				est_c = EST_NEG_MAX;
			end else begin
				est_c = -mdiv_q[EST_W-1:0];
			end
		end else if (mdiv_q > SUM_W'(EST_POS_MAX)) begin
			est_c = EST_POS_MAX;
		end else begin
			est_c = mdiv_q[EST_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (loc_valid) begin
					state_d = take_thr ? ST_RECIP : ST_ACC;
				end
			end
			ST_RECIP: begin
				if (step_q == '0) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC:   state_d = last_q ? ST_MINIT : ST_IDLE;
			ST_MINIT: state_d = (cnt_q == '0) ? ST_LOAD : ST_MEAN;
			ST_MEAN: begin
				if (step_q == '0) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// threshold, accumulator, count, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_frequency_q <= FREQ_W'(MINF_RST);
			sum_q           <= '0;
			cnt_q           <= '0;
			res_valid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				min_frequency_q <= min_frequency;
			end
			if (state_q == ST_ACC && add_q) begin
				sum_q <= sum_next;
				if (cnt_q < CNT_W'(MAX_LOCI)) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (state_q == ST_LOAD && res_free) begin
				sum_q       <= '0;
				cnt_q       <= '0;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// item capture and the two serial dividers
	always_ff @(posedge clk) begin
		if (accept) begin
			homo_q <= is_homozygous;
			freq_q <= allele_frequency;
			last_q <= last_locus;
			add_q  <= !is_homozygous || take_thr;
			rrem_q <= '0;
			quo_q  <= '0;
			step_q <= STEP_W'(QW - 1);
		end
		if (state_q == ST_RECIP) begin
			rrem_q <= rge ? rrem_sub[FREQ_W-1:0] : rrem2[FREQ_W-1:0];
			quo_q  <= {quo_q[QW-2:0], rge};
			step_q <= step_q - 1'b1;
		end
		if (state_q == ST_MINIT) begin
			neg_q  <= sum_q[SUM_W-1];
			mdiv_q <= mag;
			mrem_q <= '0;
			step_q <= STEP_W'(SUM_W - 1);
		end
		if (state_q == ST_MEAN) begin
			mrem_q <= mge ? mrem_sub[CNT_W-1:0] : mrem2[CNT_W-1:0];
			mdiv_q <= {mdiv_q[SUM_W-2:0], mge};
			step_q <= step_q - 1'b1;
		end
		if (state_q == ST_LOAD && res_free) begin
			estimate_q <= est_c;
			used_q     <= USED_W'(cnt_q);
		end
	end

endmodule

>>> rtl/mie_checker.sv
// Port-level checks for the multilocus inbreeding estimator.
// Depends on mie_pkg; bound to multilocus_inbreeding_estimate below.
module mie_checker #(
	parameter int MAX_LOCI = 1048576
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        loc_valid,
	input logic                        loc_stall,
	input logic                        res_valid,
	input logic                        res_stall,
	input logic [mie_pkg::EST_W-1:0]   estimate,
	input logic [mie_pkg::USED_W-1:0]  used_loci
);
	import mie_pkg::*;

	// a held result keeps its value
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(estimate) && $stable(used_loci))
		else $error("result changed while stalled");

	// one locus at a time: an accepted item blocks the next cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		loc_valid && !loc_stall |=> loc_stall)
		else $error("locus accepted back to back");

	// no contributing loci means a zero estimate
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (used_loci == '0) && (MAX_LOCI < (1 << USED_W)) |-> estimate == '0)
		else $error("nonzero estimate with no loci");

	// count saturates at its limit
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (MAX_LOCI < (1 << USED_W)) |-> used_loci <= USED_W'(MAX_LOCI))
		else $error("used loci above limit");

endmodule

bind multilocus_inbreeding_estimate mie_checker #(.MAX_LOCI(MAX_LOCI)) u_mie_checker (.*);

>>> tb/multilocus_inbreeding_estimate_test.sv
// Testbench for multilocus_inbreeding_estimate: drives locus items, threshold writes
// and result stalls, and checks every result against a built-in fixed-point predictor.
// Depends on mie_pkg and the multilocus_inbreeding_estimate RTL.
module multilocus_inbreeding_estimate_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mie_pkg::*;

	localparam int FRAC      = FRAC_BITS;
	localparam int LOCI_CAP  = 1048576;
	localparam int HOLD_LEN  = 400;
	localparam int SETTLE    = 120;
	localparam int PHASE_ITEMS = 155;
	localparam freq_t FREQ_MAX = {FREQ_W{1'b1}};
	localparam freq_t THR_RESET = 66;

	// Running mean of per-locus contributions, one expected result per closed locus set
	class inbreeding_scoreboard;
		freq_t threshold;
		longint contribution_sum;
		longint unsigned locus_count;
		logic [EST_W-1:0] est_q[$];
		logic [USED_W-1:0] used_q[$];
		int errors;

		function new();
			threshold = THR_RESET;
			contribution_sum = 0;
			locus_count = 0;
			errors = 0;
		endfunction

		function void add_contribution(longint c);
			longint s;
			s = contribution_sum + c;
			if (s > (longint'(1) <<< 55) - 1)
				s = (longint'(1) <<< 55) - 1;
			if (s < -(longint'(1) <<< 55))
				s = -(longint'(1) <<< 55);
			contribution_sum = s;
			if (locus_count < LOCI_CAP)
				locus_count++;
		endfunction

		function void note_locus(bit homo, freq_t freq, bit last);
			longint unsigned recip, mag, q;
			longint est;
			if (homo) begin
				if (freq > threshold) begin
					recip = (longint'(1) << (2 * FRAC)) / longint'(freq);
					add_contribution(longint'(recip) - (longint'(1) << FRAC));
				end
			end else begin
				add_contribution(-(longint'(1) << FRAC));
			end
			if (!last)
				return;
			if (locus_count == 0) begin
				est = 0;
			end else begin
				mag = (contribution_sum < 0) ? -contribution_sum : contribution_sum;
				q = mag / locus_count;
				if (contribution_sum < 0)
					est = (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
				else
					est = (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
			end
			est_q.insert(est_q.size(), est[EST_W-1:0]);
			used_q.insert(used_q.size(), locus_count[USED_W-1:0]);
			contribution_sum = 0;
			locus_count = 0;
		endfunction

		function void check_result(logic [EST_W-1:0] est, logic [USED_W-1:0] used);
			logic [EST_W-1:0] exp_est;
			logic [USED_W-1:0] exp_used;
			if (est_q.size() == 0) begin
				$error("result with nothing expected: estimate %0d used_loci %0d",
					$signed(est), used);
				errors++;
				return;
			end
			exp_est = est_q[0];
			est_q.delete(0);
			exp_used = used_q[0];
			used_q.delete(0);
			if (est !== exp_est) begin
				$error("estimate: expected %0d, got %0d", $signed(exp_est), $signed(est));
				errors++;
			end
			if (used !== exp_used) begin
				$error("used_loci: expected %0d, got %0d", exp_used, used);
				errors++;
			end
		endfunction

		function int pending();
			return est_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic loc_valid;
	logic loc_stall;
	logic is_homozygous;
	freq_t allele_frequency;
	logic last_locus;
	logic res_valid;
	logic res_stall;
	logic [EST_W-1:0] estimate;
	logic [USED_W-1:0] used_loci;
	logic cfg_valid;
	logic cfg_ready;
	freq_t min_frequency;

	inbreeding_scoreboard scoreboard = new();
	freq_t cur_threshold = THR_RESET;
	bit hold_req = 1'b0;
	int burst_left = 0;
	int counted_items = 0;

	multilocus_inbreeding_estimate #(
		.MAX_LOCI  (LOCI_CAP)
	) u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.loc_valid        (loc_valid),
		.loc_stall        (loc_stall),
		.is_homozygous    (is_homozygous),
		.allele_frequency (allele_frequency),
		.last_locus       (last_locus),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.estimate         (estimate),
		.used_loci        (used_loci),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.min_frequency    (min_frequency)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			scoreboard.check_result(estimate, used_loci);
	end

	// Result side: stall patterns that change every so often, plus one long hold on request
	initial begin
		int mode;
		int left;
		mode = 0;
		left = 0;
		res_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				res_stall <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(20, 200);
				end
				left--;
				case (mode)
					0: res_stall <= 1'b0;
					1: res_stall <= $urandom_range(0, 1);
					2: res_stall <= ($urandom_range(0, 9) < 8);
					default: res_stall <= (left % 4 != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	task automatic send_locus(input bit homo, input freq_t freq, input bit last);
		int gap;
		gap = 0;
		loc_valid <= 1'b1;
		is_homozygous <= homo;
		allele_frequency <= freq;
		last_locus <= last;
		do @(posedge clk); while (loc_stall);
		scoreboard.note_locus(homo, freq, last);
		if (!homo || freq > cur_threshold)
			counted_items++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
		end
		burst_left--;
		if (gap > 0) begin
			loc_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_threshold(input freq_t value);
		cfg_valid <= 1'b1;
		min_frequency <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		scoreboard.threshold = value;
		cur_threshold = value;
	endtask

	// Let every expected result drain, then give the block time to go idle
	task automatic drain();
		loc_valid <= 1'b0;
		while (scoreboard.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic freq_t pick_frequency();
		int unsigned f;
		case ($urandom_range(0, 5))
			0: f = $urandom_range(1, 512);
			1: f = cur_threshold + $urandom_range(0, 3);
			2: f = $urandom_range(60000, 70000);
			3: f = $urandom_range(0, 1) ? FREQ_MAX : 65536;
			default: f = $urandom_range(0, FREQ_MAX);
		endcase
		if (f > FREQ_MAX)
			f = FREQ_MAX;
		return freq_t'(f);
	endfunction

	task automatic send_random_set();
		int n;
		int r;
		bit homo;
		bit empty_set;
		freq_t f;
		r = $urandom_range(0, 19);
		n = (r < 12) ? $urandom_range(1, 4) : (r < 18) ? $urandom_range(5, 12) :
			$urandom_range(13, 48);
		// now and then a set whose loci all fall at or below the threshold
		empty_set = ($urandom_range(0, 19) == 0);
		for (int i = 0; i < n; i++) begin
			if (empty_set) begin
				homo = 1'b1;
				f = freq_t'($urandom_range(0, cur_threshold));
			end else begin
				homo = ($urandom_range(0, 99) < 70);
				f = pick_frequency();
			end
			send_locus(homo, f, i == n - 1);
		end
	endtask

	task automatic random_phase();
		int start;
		start = counted_items;
		while (counted_items - start < PHASE_ITEMS)
			send_random_set();
	endtask

	initial begin
		arst_n <= 1'b0;
		loc_valid <= 1'b0;
		is_homozygous <= 1'b0;
		allele_frequency <= '0;
		last_locus <= 1'b0;
		cfg_valid <= 1'b0;
		min_frequency <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset threshold: empty set, zero frequency, heterozygous, at and just above threshold
		send_locus(1'b1, 0, 1'b1);
		send_locus(1'b0, FREQ_MAX, 1'b1);
		send_locus(1'b1, THR_RESET, 1'b1);
		send_locus(1'b1, THR_RESET + 1'b1, 1'b1);
		send_locus(1'b1, 65536, 1'b1);
		send_locus(1'b1, FREQ_MAX, 1'b1);
		send_locus(1'b1, 100, 1'b0);
		send_locus(1'b0, 5, 1'b0);
		send_locus(1'b1, 30000, 1'b0);
		send_locus(1'b1, 65535, 1'b1);

		// long result hold while loci keep coming, so the input backs up
		hold_req = 1'b1;
		random_phase();
		drain();

		// zero threshold: tiny frequencies push the mean past the positive limit
		write_threshold(0);
		send_locus(1'b1, 1, 1'b1);
		send_locus(1'b1, 2, 1'b0);
		send_locus(1'b1, 3, 1'b1);
		send_locus(1'b1, 0, 1'b1);
		send_locus(1'b1, 1, 1'b0);
		send_locus(1'b0, 0, 1'b1);
		random_phase();
		drain();

		// threshold of one, the highest written here: only homozygous frequencies above one count
		write_threshold(65536);
		send_locus(1'b1, 65536, 1'b1);
		send_locus(1'b1, 65537, 1'b1);
		send_locus(1'b1, FREQ_MAX, 1'b0);
		send_locus(1'b0, 0, 1'b1);
		random_phase();
		drain();

		write_threshold(freq_t'($urandom_range(0, 65536)));
		random_phase();
		drain();

		write_threshold(freq_t'($urandom_range(0, 2000)));
		random_phase();
		drain();

		write_threshold(THR_RESET);
		random_phase();
		drain();

		if (scoreboard.errors == 0 && scoreboard.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#8ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
